FILE: rtl/pdc_pkg.sv
// Package for the dual-axis PD position controller: widths, register indexes,
// reset values and the structs shared by the register block, the axis unit and the top level.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package pdc_pkg;

   localparam int COUNT_WIDTH     = 24;
   localparam int LIMIT_WIDTH     = 23;
   localparam int CMP_WIDTH       = ((COUNT_WIDTH > LIMIT_WIDTH) ? COUNT_WIDTH : LIMIT_WIDTH) + 1;
   localparam int ERR_WIDTH       = COUNT_WIDTH + 2;
   localparam int DER_WIDTH       = ERR_WIDTH + 5;
   localparam int SPD_WIDTH       = ERR_WIDTH + 12;
   localparam int GAIN_WIDTH      = 6;
   localparam int SPEED_WIDTH     = 8;
   localparam int DEADBAND_WIDTH  = 10;
   localparam int CSR_ADDR_WIDTH  = 3;
   localparam int CSR_DATA_WIDTH  = 23;
   localparam int REQ_BITS        = 4 * COUNT_WIDTH + 2;
   localparam int REQ_TDATA_WIDTH = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS        = 2 * (SPEED_WIDTH + 2);
   localparam int RSP_TDATA_WIDTH = ((RSP_BITS + 7) / 8) * 8;

   localparam logic [SPEED_WIDTH-1:0]    MAX_SPEED_RESET      = SPEED_WIDTH'(180);
   localparam logic [DEADBAND_WIDTH-1:0] DEADBAND_RESET       = DEADBAND_WIDTH'(10);
   localparam logic [GAIN_WIDTH-1:0]     KP_RESET             = GAIN_WIDTH'(7);
   localparam logic [GAIN_WIDTH-1:0]     KD_RESET             = GAIN_WIDTH'(4);
   localparam logic [LIMIT_WIDTH-1:0]    PAN_REF_LIMIT_RESET  = LIMIT_WIDTH'(4764);
   localparam logic [LIMIT_WIDTH-1:0]    TILT_REF_LIMIT_RESET = LIMIT_WIDTH'(1048);

   typedef enum logic [CSR_ADDR_WIDTH-1:0] {
      CSR_MAX_SPEED      = 3'd0,
      CSR_DEADBAND       = 3'd1,
      CSR_PAN_KP         = 3'd2,
      CSR_PAN_KD         = 3'd3,
      CSR_TILT_KP        = 3'd4,
      CSR_TILT_KD        = 3'd5,
      CSR_PAN_REF_LIMIT  = 3'd6,
      CSR_TILT_REF_LIMIT = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [SPEED_WIDTH-1:0]    max_speed;
      logic [DEADBAND_WIDTH-1:0] deadband;
      logic [GAIN_WIDTH-1:0]     pan_kp;
      logic [GAIN_WIDTH-1:0]     pan_kd;
      logic [GAIN_WIDTH-1:0]     tilt_kp;
      logic [GAIN_WIDTH-1:0]     tilt_kd;
      logic [LIMIT_WIDTH-1:0]    pan_ref_limit;
      logic [LIMIT_WIDTH-1:0]    tilt_ref_limit;
   } cfg_type;

   typedef struct packed {
      logic                   forward;
      logic [SPEED_WIDTH-1:0] duty;
      logic                   drive;
   } axis_res_type;

endpackage

`default_nettype wire

FILE: rtl/pdc_csr.sv
// Configuration registers of the PD position controller, written through a plain write port.
// Depends on pdc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pdc_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_wr_en,
   input  wire logic [pdc_pkg::CSR_ADDR_WIDTH-1:0] csr_addr,
   input  wire logic [pdc_pkg::CSR_DATA_WIDTH-1:0] csr_wdata,
   output pdc_pkg::cfg_type                        cfg
);

   pdc_pkg::cfg_type cfg_ff;
   pdc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (pdc_pkg::csr_index_type'(csr_addr))
            pdc_pkg::CSR_MAX_SPEED: begin
               cfg_in.max_speed = csr_wdata[pdc_pkg::SPEED_WIDTH-1:0];
            end
            pdc_pkg::CSR_DEADBAND: begin
               cfg_in.deadband = csr_wdata[pdc_pkg::DEADBAND_WIDTH-1:0];
            end
            pdc_pkg::CSR_PAN_KP: begin
               cfg_in.pan_kp = csr_wdata[pdc_pkg::GAIN_WIDTH-1:0];
            end
            pdc_pkg::CSR_PAN_KD: begin
               cfg_in.pan_kd = csr_wdata[pdc_pkg::GAIN_WIDTH-1:0];
            end
            pdc_pkg::CSR_TILT_KP: begin
               cfg_in.tilt_kp = csr_wdata[pdc_pkg::GAIN_WIDTH-1:0];
            end
            pdc_pkg::CSR_TILT_KD: begin
               cfg_in.tilt_kd = csr_wdata[pdc_pkg::GAIN_WIDTH-1:0];
            end
            pdc_pkg::CSR_PAN_REF_LIMIT: begin
               cfg_in.pan_ref_limit = csr_wdata[pdc_pkg::LIMIT_WIDTH-1:0];
            end
            pdc_pkg::CSR_TILT_REF_LIMIT: begin
               cfg_in.tilt_ref_limit = csr_wdata[pdc_pkg::LIMIT_WIDTH-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_speed      <= pdc_pkg::MAX_SPEED_RESET;
         cfg_ff.deadband       <= pdc_pkg::DEADBAND_RESET;
         cfg_ff.pan_kp         <= pdc_pkg::KP_RESET;
         cfg_ff.pan_kd         <= pdc_pkg::KD_RESET;
         cfg_ff.tilt_kp        <= pdc_pkg::KP_RESET;
         cfg_ff.tilt_kd        <= pdc_pkg::KD_RESET;
         cfg_ff.pan_ref_limit  <= pdc_pkg::PAN_REF_LIMIT_RESET;
         cfg_ff.tilt_ref_limit <= pdc_pkg::TILT_REF_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: rtl/pdc_axis.sv
// Combinational PD law for one axis: ref clamp, error, derivative, speed, saturation, deadband.
// Depends on pdc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pdc_axis (
   input  wire logic signed [pdc_pkg::COUNT_WIDTH-1:0]    ref_pos,
   input  wire logic signed [pdc_pkg::COUNT_WIDTH-1:0]    count,
   input  wire logic signed [pdc_pkg::CMP_WIDTH-1:0]      ref_lo,
   input  wire logic signed [pdc_pkg::CMP_WIDTH-1:0]      ref_hi,
   input  wire logic signed [pdc_pkg::ERR_WIDTH-1:0]      last_err,
   input  wire logic        [pdc_pkg::GAIN_WIDTH-1:0]     kp,
   input  wire logic        [pdc_pkg::GAIN_WIDTH-1:0]     kd,
   input  wire logic        [pdc_pkg::SPEED_WIDTH-1:0]    max_speed,
   input  wire logic        [pdc_pkg::DEADBAND_WIDTH-1:0] deadband,
   input  wire logic                                      use_deadband,
   output logic signed      [pdc_pkg::ERR_WIDTH-1:0]      err,
   output pdc_pkg::axis_res_type                          res
);

   logic signed [pdc_pkg::CMP_WIDTH-1:0] ref_wide;
   logic signed [pdc_pkg::CMP_WIDTH-1:0] ref_clamped;
   logic signed [pdc_pkg::DER_WIDTH-1:0] diff;
   logic signed [pdc_pkg::DER_WIDTH-1:0] der;
   logic signed [pdc_pkg::SPD_WIDTH-1:0] p_term;
   logic signed [pdc_pkg::SPD_WIDTH-1:0] d_term;
   logic signed [pdc_pkg::SPD_WIDTH-1:0] spd;
   logic signed [pdc_pkg::SPD_WIDTH-1:0] max_pos;
   logic signed [pdc_pkg::SPD_WIDTH-1:0] sat;
   logic signed [pdc_pkg::SPD_WIDTH-1:0] sat_abs;
   logic        [pdc_pkg::ERR_WIDTH-1:0] mag;
   logic                                 coast;

   always_comb begin
      ref_wide = pdc_pkg::CMP_WIDTH'(ref_pos);
      if (ref_wide < ref_lo) begin
         ref_clamped = ref_lo;
      end else if (ref_wide > ref_hi) begin
         ref_clamped = ref_hi;
      end else begin
         ref_clamped = ref_wide;
      end

      // The clamped reference always lies inside the count range.
      err = pdc_pkg::ERR_WIDTH'($signed(ref_clamped[pdc_pkg::COUNT_WIDTH-1:0]))
          - pdc_pkg::ERR_WIDTH'(count);

      diff = pdc_pkg::DER_WIDTH'(err) - pdc_pkg::DER_WIDTH'(last_err);
      der  = (diff <<< 3) + (diff <<< 1);

      p_term = pdc_pkg::SPD_WIDTH'($signed({1'b0, kp})) * pdc_pkg::SPD_WIDTH'(err);
      d_term = pdc_pkg::SPD_WIDTH'($signed({1'b0, kd})) * pdc_pkg::SPD_WIDTH'(der);
      spd    = p_term + d_term;

      max_pos = pdc_pkg::SPD_WIDTH'($signed({1'b0, max_speed}));
      if (spd > max_pos) begin
         sat = max_pos;
      end else if (spd < -max_pos) begin
         sat = -max_pos;
      end else begin
         sat = spd;
      end
      sat_abs = (sat < 0) ? -sat : sat;

      mag   = (err < 0) ? pdc_pkg::ERR_WIDTH'(-err) : pdc_pkg::ERR_WIDTH'(err);
      coast = use_deadband && (mag < pdc_pkg::ERR_WIDTH'(deadband));

      if (coast) begin
         res = '0;
      end else begin
         res.drive   = 1'b1;
         res.duty    = sat_abs[pdc_pkg::SPEED_WIDTH-1:0];
         res.forward = (sat > 0);
      end
   end

endmodule

`default_nettype wire

FILE: rtl/dual_axis_pd_position_controller_core.sv
// Top level of the dual-axis PD position controller: request register, two axis units,
// stored errors and the response register. Depends on pdc_pkg, pdc_csr and pdc_axis.
//
//   Channel   Direction  Handshake                 Payload
//   req_*     in         req_tvalid / req_tready   pan/tilt refs, counts, mode flags
//   rsp_*     out        rsp_tvalid / rsp_tready   per-axis drive, duty, forward
//   csr_*     in         csr_wr_en                 csr_addr, csr_wdata
//
// A request is registered on acceptance; its result enters the response register when that
// is free, and one request is taken every cycle while responses do not stall. The response
// register separates the sides: while a response waits, an empty request register accepts.
// Reset is synchronous; it restores the register defaults and clears both stored errors.
// A stalled response holds the request register, which then holds back req_tready.
`timescale 1ns / 1ps
`default_nettype none

module dual_axis_pd_position_controller_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // From bit 0: pan_ref, tilt_ref, pan_count, tilt_count, spray_mode, fire_present, zeros.
   input  wire logic [pdc_pkg::REQ_TDATA_WIDTH-1:0] req_tdata,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // From bit 0: pan_drive, pan_duty, pan_forward, tilt_drive, tilt_duty, tilt_forward, zeros.
   output logic [pdc_pkg::RSP_TDATA_WIDTH-1:0]      rsp_tdata,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   input  wire logic                                csr_wr_en,
   input  wire logic [pdc_pkg::CSR_ADDR_WIDTH-1:0]  csr_addr,
   input  wire logic [pdc_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   localparam int CW = pdc_pkg::COUNT_WIDTH;

   pdc_pkg::cfg_type cfg;

   logic                                 req_valid_ff;
   logic                                 req_valid_in;
   logic signed [CW-1:0]                 pan_ref_ff;
   logic signed [CW-1:0]                 tilt_ref_ff;
   logic signed [CW-1:0]                 pan_count_ff;
   logic signed [CW-1:0]                 tilt_count_ff;
   logic                                 spray_ff;
   logic                                 fire_ff;

   logic signed [pdc_pkg::ERR_WIDTH-1:0] last_pan_err_ff;
   logic signed [pdc_pkg::ERR_WIDTH-1:0] last_pan_err_in;
   logic signed [pdc_pkg::ERR_WIDTH-1:0] last_tilt_err_ff;
   logic signed [pdc_pkg::ERR_WIDTH-1:0] last_tilt_err_in;

   logic                                 rsp_valid_ff;
   logic                                 rsp_valid_in;
   pdc_pkg::axis_res_type                pan_res_ff;
   pdc_pkg::axis_res_type                pan_res_in;
   pdc_pkg::axis_res_type                tilt_res_ff;
   pdc_pkg::axis_res_type                tilt_res_in;

   logic                                 req_fire;
   logic                                 advance;
   logic                                 active;
   logic signed [pdc_pkg::CMP_WIDTH-1:0] pan_hi;
   logic signed [pdc_pkg::CMP_WIDTH-1:0] pan_lo;
   logic signed [pdc_pkg::CMP_WIDTH-1:0] tilt_hi;
   logic signed [pdc_pkg::ERR_WIDTH-1:0] pan_err;
   logic signed [pdc_pkg::ERR_WIDTH-1:0] tilt_err;
   pdc_pkg::axis_res_type                pan_res;
   pdc_pkg::axis_res_type                tilt_res;

   pdc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign pan_hi  = $signed(pdc_pkg::CMP_WIDTH'(cfg.pan_ref_limit));
   assign pan_lo  = -pan_hi;
   assign tilt_hi = $signed(pdc_pkg::CMP_WIDTH'(cfg.tilt_ref_limit));

   pdc_axis u_pan_axis (
      .ref_pos      (pan_ref_ff),
      .count        (pan_count_ff),
      .ref_lo       (pan_lo),
      .ref_hi       (pan_hi),
      .last_err     (last_pan_err_ff),
      .kp           (cfg.pan_kp),
      .kd           (cfg.pan_kd),
      .max_speed    (cfg.max_speed),
      .deadband     (cfg.deadband),
      .use_deadband (!spray_ff),
      .err          (pan_err),
      .res          (pan_res)
   );

   pdc_axis u_tilt_axis (
      .ref_pos      (tilt_ref_ff),
      .count        (tilt_count_ff),
      .ref_lo       ('0),
      .ref_hi       (tilt_hi),
      .last_err     (last_tilt_err_ff),
      .kp           (cfg.tilt_kp),
      .kd           (cfg.tilt_kd),
      .max_speed    (cfg.max_speed),
      .deadband     (cfg.deadband),
      .use_deadband (!spray_ff),
      .err          (tilt_err),
      .res          (tilt_res)
   );

   always_comb begin
      advance    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
      req_tready = !req_valid_ff || advance;
      req_fire   = req_tvalid && req_tready;
      active     = spray_ff || fire_ff;

      if (req_fire) begin
         req_valid_in = 1'b1;
      end else if (advance) begin
         req_valid_in = 1'b0;
      end else begin
         req_valid_in = req_valid_ff;
      end

      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      last_pan_err_in  = last_pan_err_ff;
      last_tilt_err_in = last_tilt_err_ff;
      pan_res_in       = pan_res_ff;
      tilt_res_in      = tilt_res_ff;
      if (advance) begin
         if (active) begin
            last_pan_err_in  = pan_err;
            last_tilt_err_in = tilt_err;
            pan_res_in       = pan_res;
            tilt_res_in      = tilt_res;
         end else begin
            pan_res_in       = '0;
            tilt_res_in      = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff     <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         last_pan_err_ff  <= '0;
         last_tilt_err_ff <= '0;
      end else begin
         req_valid_ff     <= req_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
         last_pan_err_ff  <= last_pan_err_in;
         last_tilt_err_ff <= last_tilt_err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         pan_ref_ff    <= $signed(req_tdata[CW-1:0]);
         tilt_ref_ff   <= $signed(req_tdata[2*CW-1:CW]);
         pan_count_ff  <= $signed(req_tdata[3*CW-1:2*CW]);
         tilt_count_ff <= $signed(req_tdata[4*CW-1:3*CW]);
         spray_ff      <= req_tdata[4*CW];
         fire_ff       <= req_tdata[4*CW+1];
      end
      pan_res_ff  <= pan_res_in;
      tilt_res_ff <= tilt_res_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = pdc_pkg::RSP_TDATA_WIDTH'({tilt_res_ff, pan_res_ff});

   a_pan_coast_quiet : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !pan_res_ff.drive |-> pan_res_ff.duty == '0 && !pan_res_ff.forward)
      else $error("pan coasts with nonzero duty or forward");

   a_tilt_forward_duty : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && tilt_res_ff.forward |-> tilt_res_ff.duty != '0 && tilt_res_ff.drive)
      else $error("tilt forward without duty");

   a_state_kept_idle_mode : assert property (@(posedge clock) disable iff (reset)
      advance && !active |=> $stable(last_pan_err_ff) && $stable(last_tilt_err_ff))
      else $error("stored error changed with no mode set");

   a_no_rsp_after_reset : assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule

`default_nettype wire
